// File: design/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the PID speed controller: register indexes,
// register reset values and the control/status bundles between modules.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIVE     = 3'd5;

  localparam logic [15:0] PROP_GAIN_RST     = 16'd256;
  localparam logic [15:0] INTEG_GAIN_RST    = 16'd0;
  localparam logic [15:0] DERIV_GAIN_RST    = 16'd0;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;
  localparam logic [15:0] SAMPLE_RATE_RST   = 16'd100;
  localparam logic [15:0] MAX_DRIVE_RST     = 16'd65535;

  // magnitude handed to the divide-by-five unit and its quotient
  localparam int unsigned DIV_IN_W  = 58;
  localparam int unsigned DIV_OUT_W = 56;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [15:0] sample_period;
    logic [15:0] sample_rate;
    logic [15:0] max_drive;
  } psc_cfg_t;

  typedef struct packed {
    logic take_in;
    logic mul_kd;
    logic mul_rate;
    logic div_load;
    logic integ;
    logic mul_i;
    logic add_i;
    logic add_d;
    logic load_out;
  } psc_cmd_t;

  typedef struct packed {
    logic div_done;
  } psc_status_t;

endpackage

// File: design/psc_div5.sv
// ----------------------------------------------------------------------------
// psc_div5
// Unsigned divide by five, one radix-256 digit per cycle. Each step divides
// the running remainder and the next byte by a reciprocal multiply.
// ----------------------------------------------------------------------------
module psc_div5
  import psc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_IN_W-1:0]  dividend,
  output logic                 done,
  output logic [DIV_OUT_W-1:0] quotient
);

  localparam int unsigned DVD_W = 64;
  localparam int unsigned STEPS = DVD_W / 8;

  logic [DVD_W-1:0] dvd;
  logic [2:0]       rem;
  logic [2:0]       cnt;
  logic             busy;

  logic [10:0] step_v;
  logic [22:0] step_p;
  logic [7:0]  step_q;
  logic [10:0] step_r;

  // v < 1280, so v * 3277 / 2^14 floors to v / 5 exactly
  assign step_v = {rem, dvd[DVD_W-1 -: 8]};
  assign step_p = 23'(step_v) * 23'd3277;
  assign step_q = step_p[21:14];
  assign step_r = step_v - 11'(step_q) * 11'd5;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {{(DVD_W-DIV_IN_W){1'b0}}, dividend};
      rem <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_W-9:0], 8'd0};
      rem      <= step_r[2:0];
      quotient <= {quotient[DIV_OUT_W-9:0], step_q};
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

// File: design/psc_datapath.sv
// ----------------------------------------------------------------------------
// psc_datapath
// Error, shared multiplier, clamped integral, filtered derivative and the
// output sum, stepped by commands from the controller.
// ----------------------------------------------------------------------------
module psc_datapath
  import psc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  psc_cfg_t           cfg,
  input  psc_cmd_t           cmd,
  output psc_status_t        status,
  input  logic signed [15:0] setpoint,
  input  logic signed [15:0] measurement,
  output logic [15:0]        drive
);

  logic signed [16:0] err;
  logic signed [17:0] derr;
  logic signed [16:0] last_error;
  logic signed [31:0] integral_sum;
  logic signed [47:0] filtered_deriv;
  logic signed [49:0] prod;
  logic signed [49:0] acc;
  logic               deriv_neg;

  logic signed [16:0] err_next;
  logic signed [33:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [50:0] mul_full;
  logic signed [58:0] xsum;
  logic signed [58:0] xmag;
  logic               xneg;
  logic signed [33:0] isum;
  logic signed [33:0] lim;
  logic signed [31:0] integral_next;
  logic signed [47:0] deriv_sat;
  logic [33:0]        whole;
  logic [15:0]        drive_next;
  logic [DIV_OUT_W-1:0] div_q;
  logic               div_done;

  assign err_next = $signed({setpoint[15], setpoint}) - $signed({measurement[15], measurement});

  // shared multiplier: signed operand times an unsigned register
  always_comb begin
    mul_a = 34'(err);
    mul_b = cfg.prop_gain;
    if (cmd.mul_kd) begin
      mul_a = 34'(derr);
      mul_b = cfg.deriv_gain;
    end else if (cmd.mul_rate) begin
      mul_a = prod[33:0];
      mul_b = cfg.sample_rate;
    end else if (cmd.div_load) begin
      mul_a = 34'(err);
      mul_b = cfg.sample_period;
    end else if (cmd.mul_i) begin
      mul_a = 34'(integral_sum);
      mul_b = cfg.integ_gain;
    end
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // new derivative sample plus four times the previous filter value
  assign xsum = $signed({prod[49], prod, 8'd0})
              + $signed({{9{filtered_deriv[47]}}, filtered_deriv, 2'd0});
  assign xneg = xsum[58];
  assign xmag = xneg ? -xsum : xsum;

  psc_div5 u_div5 (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_load),
    .dividend (xmag[DIV_IN_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign status.div_done = div_done;

  // truncating divide: magnitude quotient with the sign put back, then saturate
  always_comb begin
    if (!deriv_neg) begin
      if (div_q > DIV_OUT_W'(48'h7FFF_FFFF_FFFF)) deriv_sat = 48'sh7FFF_FFFF_FFFF;
      else                                          deriv_sat = div_q[47:0];
    end else begin
      if (div_q > DIV_OUT_W'(48'h8000_0000_0000)) deriv_sat = 48'sh8000_0000_0000;
      else                                          deriv_sat = -$signed(div_q[47:0]);
    end
  end

  assign isum = $signed({{2{integral_sum[31]}}, integral_sum}) + prod[33:0];
  assign lim  = $signed({3'd0, cfg.max_drive, 15'd0});

  always_comb begin
    if (isum > lim)       integral_next = lim[31:0];
    else if (isum < -lim) integral_next = 32'(-lim);
    else                  integral_next = isum[31:0];
  end

  assign whole = acc[49:16];

  always_comb begin
    if (acc[49])                           drive_next = '0;
    else if (whole > {18'd0, cfg.max_drive}) drive_next = cfg.max_drive;
    else                                   drive_next = whole[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error     <= '0;
      integral_sum   <= '0;
      filtered_deriv <= '0;
    end else begin
      if (cmd.take_in) begin
        last_error <= err_next;
      end
      if (cmd.integ) begin
        integral_sum <= integral_next;
      end
      if (cmd.add_d) begin
        filtered_deriv <= deriv_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      err  <= err_next;
      derr <= $signed({err_next[16], err_next}) - $signed({last_error[16], last_error});
    end
    // sign of the filter sum, held while the multiplier moves on
    if (cmd.div_load) begin
      deriv_neg <= xneg;
    end
    if (cmd.mul_kd || cmd.mul_rate || cmd.div_load || cmd.integ || cmd.mul_i) begin
      prod <= mul_full[49:0];
    end
    if (cmd.mul_i) begin
      acc <= $signed({prod[41:0], 8'd0});
    end else if (cmd.add_i) begin
      acc <= acc + $signed({{8{prod[49]}}, prod[49:8]});
    end else if (cmd.add_d) begin
      acc <= acc + $signed({{2{deriv_sat[47]}}, deriv_sat});
    end
    if (cmd.load_out) begin
      drive <= drive_next;
    end
  end

endmodule

// File: design/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer for one control tick: input transfer, multiplier schedule,
// wait on the divider, and the output register's valid flag.
// ----------------------------------------------------------------------------
module psc_ctrl
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  psc_status_t status,
  output psc_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_KD,
    S_RATE,
    S_DLOAD,
    S_INTEG,
    S_MULI,
    S_ADDI,
    S_WAIT,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.take_in  = (state == S_IDLE) && in_valid;
    cmd.mul_kd   = (state == S_KD);
    cmd.mul_rate = (state == S_RATE);
    cmd.div_load = (state == S_DLOAD);
    cmd.integ    = (state == S_INTEG);
    cmd.mul_i    = (state == S_MULI);
    cmd.add_i    = (state == S_ADDI);
    cmd.add_d    = (state == S_WAIT) && status.div_done;
    cmd.load_out = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_KD;
        end
        S_KD:    state <= S_RATE;
        S_RATE:  state <= S_DLOAD;
        S_DLOAD: state <= S_INTEG;
        S_INTEG: state <= S_MULI;
        S_MULI:  state <= S_ADDI;
        S_ADDI:  state <= S_WAIT;
        S_WAIT: begin
          if (status.div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_KD))
    else $error("input transfer did not start a tick");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken result");
  a_deriv_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.add_d |-> status.div_done)
    else $error("derivative used before the divide finished");

endmodule

// File: design/pid_speed_controller.sv
// ----------------------------------------------------------------------------
// pid_speed_controller
// Fixed-point PID speed controller with clamped integral and low-pass
// filtered derivative; holds the configuration registers.
//
//   channel   signals                                  direction
//   input     in_valid in_ready setpoint measurement   in
//   output    out_valid out_ready drive                out
//   config    cfg_valid cfg_ready cfg_index cfg_data   in
//
// The next input is taken only after the current tick is through, which waits
// on the eight radix-256 steps of the divide-by-five unit in the
// derivative filter; products run one at a time on a single multiplier.
// Reset clears the controller state, integral, last error and filter, and
// loads the register reset values. A result waiting in the output register
// does not block the next input; a new result waits until it is taken.
// ----------------------------------------------------------------------------
module pid_speed_controller
  import psc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   setpoint,
  input  logic signed [15:0]   measurement,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          drive,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  psc_cfg_t    cfg;
  psc_cmd_t    cmd;
  psc_status_t status;

  assign cfg_ready = 1'b1;

  // indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= PROP_GAIN_RST;
      cfg.integ_gain    <= INTEG_GAIN_RST;
      cfg.deriv_gain    <= DERIV_GAIN_RST;
      cfg.sample_period <= SAMPLE_PERIOD_RST;
      cfg.sample_rate   <= SAMPLE_RATE_RST;
      cfg.max_drive     <= MAX_DRIVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROP_GAIN:     cfg.prop_gain     <= cfg_data;
        CFG_INTEG_GAIN:    cfg.integ_gain    <= cfg_data;
        CFG_DERIV_GAIN:    cfg.deriv_gain    <= cfg_data;
        CFG_SAMPLE_PERIOD: cfg.sample_period <= cfg_data;
        CFG_SAMPLE_RATE:   cfg.sample_rate   <= cfg_data;
        CFG_MAX_DRIVE:     cfg.max_drive     <= cfg_data;
        default: ;
      endcase
    end
  end

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  psc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .setpoint    (setpoint),
    .measurement (measurement),
    .drive       (drive)
  );

endmodule

// File: tb/pid_drive_checker.sv
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the configuration, input and output channels of the PID speed
// controller. Keeps its own copy of the registers and the controller state,
// predicts the drive for every input transfer and compares each output
// transfer with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pid_drive_checker
  import psc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [15:0]   setpoint,
  input  logic signed [15:0]   measurement,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [15:0]          drive,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam longint FILT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FILT_MIN = -FILT_MAX - 64'sd1;

  psc_cfg_t    regs;
  longint      integ_acc;
  longint      prev_err;
  longint      filt_deriv;
  logic [15:0] pending_drives[$];
  int          mismatches = 0;
  int          queued     = 0;

  assign fail_count  = mismatches;
  assign outstanding = queued;

  function automatic longint u16(input logic [15:0] v);
    return longint'({48'd0, v});
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // one control tick: updates integral, filter and last error, returns drive
  function automatic logic [15:0] next_drive(input logic signed [15:0] sp,
                                             input logic signed [15:0] ms);
    longint err;
    longint lim;
    longint prop_t;
    longint integ_t;
    longint raw;
    longint deriv;
    longint total;
    longint whole;
    err = longint'(sp) - longint'(ms);
    lim = u16(regs.max_drive) * 64'sd32768;

    integ_acc = integ_acc + err * u16(regs.sample_period);
    if (integ_acc > lim) integ_acc = lim;
    else if (integ_acc < -lim) integ_acc = -lim;

    prop_t  = u16(regs.prop_gain) * err * 64'sd256;
    integ_t = (u16(regs.integ_gain) * integ_acc) >>> 8;

    raw   = u16(regs.deriv_gain) * (err - prev_err) * u16(regs.sample_rate) * 64'sd256;
    // signed divide truncates toward zero
    deriv = (raw + 64'sd4 * filt_deriv) / 64'sd5;
    if (deriv > FILT_MAX) deriv = FILT_MAX;
    else if (deriv < FILT_MIN) deriv = FILT_MIN;
    filt_deriv = deriv;
    prev_err   = err;

    total = prop_t + integ_t + deriv;
    if (total < 0) begin
      whole = 0;
    end else begin
      whole = total >>> 16;
      if (whole > u16(regs.max_drive)) whole = u16(regs.max_drive);
    end
    return whole[15:0];
  endfunction

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      regs.prop_gain     = PROP_GAIN_RST;
      regs.integ_gain    = INTEG_GAIN_RST;
      regs.deriv_gain    = DERIV_GAIN_RST;
      regs.sample_period = SAMPLE_PERIOD_RST;
      regs.sample_rate   = SAMPLE_RATE_RST;
      regs.max_drive     = MAX_DRIVE_RST;
      integ_acc  = 0;
      prev_err   = 0;
      filt_deriv = 0;
      pending_drives.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP_GAIN:     regs.prop_gain     = cfg_data;
          CFG_INTEG_GAIN:    regs.integ_gain    = cfg_data;
          CFG_DERIV_GAIN:    regs.deriv_gain    = cfg_data;
          CFG_SAMPLE_PERIOD: regs.sample_period = cfg_data;
          CFG_SAMPLE_RATE:   regs.sample_rate   = cfg_data;
          CFG_MAX_DRIVE:     regs.max_drive     = cfg_data;
          default: ;
        endcase
      end
      // output first: a result and a new input can share one edge
      if (out_valid && out_ready) begin
        if (pending_drives.size() == 0) begin
          flag_mismatch($sformatf("drive %0d with no result pending", drive));
        end else begin
          want = pending_drives.pop_front();
          if (drive !== want)
            flag_mismatch($sformatf("drive expected %0d got %0d", want, drive));
        end
      end
      if (in_valid && in_ready)
        pending_drives.push_back(next_drive(setpoint, measurement));
    end
    queued <= pending_drives.size();
  end

endmodule

// File: tb/tb_pid_speed_controller.sv
// ----------------------------------------------------------------------------
// tb_pid_speed_controller
// Drives the PID speed controller through directed ticks at the field and
// register extremes, then random tracking and noise ticks under a series of
// register settings, with random idling on both channels. Checking is done
// by the drive checker beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_pid_speed_controller;
  import psc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TAIL_CYCLES   = 32;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 212;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_MAX_DRIVE + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic signed [15:0]   setpoint    = '0;
  logic signed [15:0]   measurement = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [15:0]          drive;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [15:0]          cfg_data    = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  bit steady      = 1'b0;

  pid_speed_controller u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .setpoint    (setpoint),
    .measurement (measurement),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive       (drive),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  pid_drive_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .setpoint    (setpoint),
    .measurement (measurement),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive       (drive),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 17);
  end

  // valid stays high between back-to-back items; lowered only for a gap
  task automatic send_item(input logic [15:0] sp, input logic [15:0] ms);
    if (!steady && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    setpoint    <= sp;
    measurement <= ms;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [15:0] kp, input logic [15:0] ki,
                            input logic [15:0] kd, input logic [15:0] period,
                            input logic [15:0] rate, input logic [15:0] max_out,
                            input bit stray);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_SAMPLE_PERIOD, period);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_MAX_DRIVE, max_out);
    // indexes past the register list must leave everything alone
    if (stray) begin
      write_reg(CFG_UNUSED_LO, 16'($urandom));
      write_reg(CFG_UNUSED_HI, 16'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_reg(input logic [15:0] hi);
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, hi));
    endcase
  endfunction

  // mostly a measurement tracking a held target, with step changes and noise
  task automatic run_random_items(input int count);
    logic [15:0] target;
    int          kind;
    target = 16'($urandom);
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) target = 16'($urandom);
      if (kind < 15)
        send_item(16'($urandom), 16'($urandom));
      else
        send_item(target, target + 16'($urandom_range(0, 400)) - 16'd200);
      if ($urandom_range(0, 299) == 0) drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, field extremes
    send_item(16'sd0, 16'sd0);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh7FFF);
    send_item(-16'sd1, -16'sd1);
    send_item(16'sd100, 16'sd90);

    // every register at its top, derivative swings hard enough to saturate
    drain();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh7FFF);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sd0, 16'sd0);
    send_item(16'sh8000, 16'sh8000);

    // zero period freezes the integral, zero rate lets the filter decay
    drain();
    set_config(16'd256, 16'd256, 16'hFFFF, 16'd0, 16'd0, 16'd1000, 1'b0);
    send_item(16'sd1000, 16'sd0);
    send_item(16'sd1000, 16'sd0);
    send_item(-16'sd1000, 16'sd0);
    send_item(16'sd5, 16'sd5);

    // zero output limit, plus writes past the register list
    drain();
    set_config(16'h4000, 16'h0100, 16'h0010, 16'd655, 16'd100, 16'd0, 1'b1);
    send_item(16'sh7FFF, 16'sd0);
    send_item(16'sh8000, 16'sd0);
    send_item(16'sd12, -16'sd12);

    drain();
    set_config(16'h0080, 16'h0200, 16'h0040, 16'd1, 16'hFFFF, 16'd40000, 1'b0);
    send_item(16'sd300, 16'sd200);
    send_item(16'sd200, 16'sd300);
    send_item(-16'sd5, 16'sd7);
    send_item(16'sd0, 16'sh8000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      set_config(pick_reg(16'd1024), pick_reg(16'd512), pick_reg(16'd256),
                 pick_reg(16'd2000), pick_reg(16'd1000), pick_reg(16'hFFFF), p[0]);
      steady = (p == 3);
      run_random_items(PHASE_ITEMS);
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
